### hw/rtl/rcd_pkg.sv
package rcd_pkg;

   localparam int unsigned KIND_W     = 2;
   localparam int unsigned INDEX_W    = 9;
   localparam int unsigned VALUE_W    = 17;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned SYMBOL_W   = 8;
   localparam int unsigned OWED_W     = 3;
   localparam int unsigned COUNT_W    = 9;
   localparam int unsigned DATA_W     = 32;

   localparam int unsigned PROB_SHIFT_DEF  = 16;
   localparam int unsigned MAX_SYMBOLS_DEF = 256;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;
   localparam logic [OWED_W-1:0]  OWED_RESET  = 3'd4;
   localparam logic [DATA_W-1:0]  RANGE_FLOOR = 32'h0100_0000;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_RESTART = 2'd0,
      KIND_LOAD    = 2'd1,
      KIND_SUPPLY  = 2'd2,
      KIND_DECODE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      RD_MID     = 2'd0,
      RD_LO      = 2'd1,
      RD_LO_NEXT = 2'd2
   } rd_sel_type;

   typedef enum logic [1:0] {
      MUL_PROBE = 2'd0,
      MUL_BEGIN = 2'd1,
      MUL_RANGE = 2'd2
   } mul_sel_type;

   typedef struct packed {
      logic        accept;
      rd_sel_type  rd_sel;
      mul_sel_type mul_sel;
      logic        mul_en;
      logic        probe_cmp;
      logic        capture_begin;
      logic        capture_end;
      logic        capture_sub;
      logic        commit;
      logic        norm_shift;
      logic        out_load;
      logic        out_err;
   } cmd_type;

   typedef struct packed {
      logic search_done;
      logic out_of_table;
      logic range_zero;
      logic range_low;
   } status_type;

endpackage

### hw/rtl/rcd_intf.sv
interface rcd_req_if;
   logic                              valid;
   logic                              ready;
   rcd_pkg::kind_type                 kind;
   logic [rcd_pkg::INDEX_W-1:0]       entry_index;
   logic [rcd_pkg::VALUE_W-1:0]       entry_value;
   logic [rcd_pkg::BYTE_W-1:0]        code_byte;

   modport source (output valid, kind, entry_index, entry_value, code_byte, input ready);
   modport sink (input valid, kind, entry_index, entry_value, code_byte, output ready);
endinterface

interface rcd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [rcd_pkg::SYMBOL_W-1:0]      symbol;
   logic                              status;
   logic [rcd_pkg::OWED_W-1:0]        bytes_owed;

   modport source (output valid, symbol, status, bytes_owed, input ready);
   modport sink (input valid, symbol, status, bytes_owed, output ready);
endinterface

interface rcd_csr_if;
   logic                              valid;
   logic                              ready;
   logic [rcd_pkg::COUNT_W-1:0]       symbol_count;

   modport source (output valid, symbol_count, input ready);
   modport sink (input valid, symbol_count, output ready);
endinterface

### hw/rtl/range_coder_decoder_unit.sv
// Restart, load and supply transactions take effect at their accepting edge; one transaction is in work at a time.
// A decode result comes after the search, zero to three renormalization shifts and any wait for
// the result register to empty. Each of the P search probes (8 or 9 for 256 symbols) is a table
// read, a multiply and a compare. An out-of-table error is reported once the search closes, an
// empty interval once the new range product is formed.
// Synchronous active-high reset: code 0, range all ones, 4 owed, 256 symbols; table not cleared.
module range_coder_decoder_unit #(
   parameter int unsigned PROB_SHIFT  = rcd_pkg::PROB_SHIFT_DEF,
   parameter int unsigned MAX_SYMBOLS = rcd_pkg::MAX_SYMBOLS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rcd_req_if.sink    req_ch,
   rcd_rsp_if.source  rsp_ch,
   rcd_csr_if.sink    csr_ch
);

   rcd_pkg::cmd_type    cmd;
   rcd_pkg::status_type status;
   logic                csr_write;

   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid && csr_ch.ready;

   rcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_kind   (req_ch.kind),
      .in_ready  (req_ch.ready),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rcd_dp #(
      .PROB_SHIFT  (PROB_SHIFT),
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .in_kind        (req_ch.kind),
      .in_entry_index (req_ch.entry_index),
      .in_entry_value (req_ch.entry_value),
      .in_code_byte   (req_ch.code_byte),
      .csr_write      (csr_write),
      .csr_data       (csr_ch.symbol_count),
      .out_symbol     (rsp_ch.symbol),
      .out_status     (rsp_ch.status),
      .out_bytes_owed (rsp_ch.bytes_owed)
   );

endmodule

### hw/rtl/rcd_dp.sv
module rcd_dp #(
   parameter int unsigned PROB_SHIFT  = rcd_pkg::PROB_SHIFT_DEF,
   parameter int unsigned MAX_SYMBOLS = rcd_pkg::MAX_SYMBOLS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rcd_pkg::cmd_type               cmd,
   output rcd_pkg::status_type            status,
   input  rcd_pkg::kind_type              in_kind,
   input  logic [rcd_pkg::INDEX_W-1:0]    in_entry_index,
   input  logic [rcd_pkg::VALUE_W-1:0]    in_entry_value,
   input  logic [rcd_pkg::BYTE_W-1:0]     in_code_byte,
   input  logic                           csr_write,
   input  logic [rcd_pkg::COUNT_W-1:0]    csr_data,
   output logic [rcd_pkg::SYMBOL_W-1:0]   out_symbol,
   output logic                           out_status,
   output logic [rcd_pkg::OWED_W-1:0]     out_bytes_owed
);

   localparam int unsigned DEPTH   = MAX_SYMBOLS + 1;
   localparam int unsigned ADDR_W  = $clog2(DEPTH);
   localparam int unsigned IDX_W   = $clog2(MAX_SYMBOLS + 2);
   localparam int unsigned SLICE_W = rcd_pkg::DATA_W - PROB_SHIFT;
   localparam int unsigned DW      = rcd_pkg::DATA_W;
   localparam int unsigned VW      = rcd_pkg::VALUE_W;
   localparam int unsigned OW      = rcd_pkg::OWED_W;

   logic [VW-1:0] dist_table_ff [DEPTH];
   logic [VW-1:0] rdata_ff;

   logic [rcd_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [DW-1:0] code_ff, code_in;
   logic [DW-1:0] range_ff, range_in;
   logic [OW-1:0] owed_ff, owed_in;
   logic [IDX_W-1:0] lo_ff, lo_in;
   logic [IDX_W-1:0] hi_ff, hi_in;
   logic [VW-1:0] begin_ff, begin_in;
   logic [VW-1:0] diff_ff, diff_in;
   logic [DW-1:0] prod_ff, prod_in;
   logic [DW-1:0] sub_ff, sub_in;
   logic [rcd_pkg::SYMBOL_W-1:0] symbol_ff, symbol_in;
   logic status_ff, status_in;
   logic [OW-1:0] bytes_owed_ff, bytes_owed_in;

   logic [SLICE_W-1:0] slice;
   logic [IDX_W-1:0] n_use;
   logic [IDX_W:0] lohi_sum;
   logic [IDX_W-1:0] mid;
   logic [IDX_W-1:0] lo_next;
   logic [ADDR_W-1:0] rd_addr;
   logic [VW-1:0] mul_b;
   logic [SLICE_W+VW-1:0] mul_full;
   logic load_write;

   assign slice    = range_ff[DW-1:PROB_SHIFT];
   assign n_use    = (32'(count_ff) > MAX_SYMBOLS) ? IDX_W'(MAX_SYMBOLS) : IDX_W'(count_ff);
   assign lohi_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid      = lohi_sum[IDX_W:1];
   assign lo_next  = lo_ff + IDX_W'(1);

   always_comb begin
      case (cmd.rd_sel)
         rcd_pkg::RD_LO:      rd_addr = ADDR_W'(lo_ff);
         rcd_pkg::RD_LO_NEXT: rd_addr = ADDR_W'(lo_next);
         default:             rd_addr = ADDR_W'(mid);
      endcase
   end

   always_comb begin
      case (cmd.mul_sel)
         rcd_pkg::MUL_BEGIN: mul_b = begin_ff;
         rcd_pkg::MUL_RANGE: mul_b = diff_ff;
         default:            mul_b = rdata_ff;
      endcase
   end

   assign mul_full = slice * mul_b;

   assign status.search_done  = (hi_ff - lo_ff) <= IDX_W'(1);
   assign status.out_of_table = lo_ff >= n_use;
   assign status.range_zero   = prod_ff == '0;
   assign status.range_low    = range_ff < rcd_pkg::RANGE_FLOOR;

   assign load_write = cmd.accept && (in_kind == rcd_pkg::KIND_LOAD) &&
                       (32'(in_entry_index) <= MAX_SYMBOLS);

   // Table storage: one write port for loads, one registered read port.
   always_ff @(posedge clock) begin
      if (load_write) begin
         dist_table_ff[ADDR_W'(in_entry_index)] <= in_entry_value;
      end
      rdata_ff <= dist_table_ff[rd_addr];
   end

   always_comb begin
      count_in      = count_ff;
      code_in       = code_ff;
      range_in      = range_ff;
      owed_in       = owed_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      begin_in      = begin_ff;
      diff_in       = diff_ff;
      prod_in       = prod_ff;
      sub_in        = sub_ff;
      symbol_in     = symbol_ff;
      status_in     = status_ff;
      bytes_owed_in = bytes_owed_ff;

      if (csr_write) begin
         count_in = csr_data;
      end

      if (cmd.accept) begin
         case (in_kind)
            rcd_pkg::KIND_RESTART: begin
               code_in  = '0;
               range_in = '1;
               owed_in  = rcd_pkg::OWED_RESET;
            end
            rcd_pkg::KIND_SUPPLY: begin
               // The byte lands at the highest position still owed.
               case (owed_ff)
                  3'd1: begin
                     code_in = code_ff | DW'(in_code_byte);
                     owed_in = owed_ff - OW'(1);
                  end
                  3'd2: begin
                     code_in = code_ff | (DW'(in_code_byte) << 8);
                     owed_in = owed_ff - OW'(1);
                  end
                  3'd3: begin
                     code_in = code_ff | (DW'(in_code_byte) << 16);
                     owed_in = owed_ff - OW'(1);
                  end
                  3'd4: begin
                     code_in = code_ff | (DW'(in_code_byte) << 24);
                     owed_in = owed_ff - OW'(1);
                  end
                  default: begin
                     owed_in = owed_ff;
                  end
               endcase
            end
            rcd_pkg::KIND_DECODE: begin
               lo_in = '0;
               hi_in = n_use + IDX_W'(1);
            end
            default: begin
               code_in = code_ff;
            end
         endcase
      end

      if (cmd.mul_en) begin
         prod_in = DW'(mul_full);
      end

      if (cmd.probe_cmp) begin
         if (prod_ff <= code_ff) begin
            lo_in = mid;
         end else begin
            hi_in = mid;
         end
      end

      if (cmd.capture_begin) begin
         begin_in = rdata_ff;
      end

      if (cmd.capture_end) begin
         diff_in = (rdata_ff > begin_ff) ? (rdata_ff - begin_ff) : '0;
      end

      if (cmd.capture_sub) begin
         sub_in = code_ff - prod_ff;
      end

      if (cmd.commit) begin
         code_in  = sub_ff;
         range_in = prod_ff;
         owed_in  = '0;
      end

      // Each renormalization step brings in a zero byte that is owed later.
      if (cmd.norm_shift) begin
         code_in  = code_ff << 8;
         range_in = range_ff << 8;
         owed_in  = owed_ff + OW'(1);
      end

      if (cmd.out_load) begin
         symbol_in     = cmd.out_err ? '0 : rcd_pkg::SYMBOL_W'(lo_ff);
         status_in     = cmd.out_err ? rcd_pkg::STATUS_ERR : rcd_pkg::STATUS_OK;
         bytes_owed_in = owed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= rcd_pkg::COUNT_RESET;
         code_ff  <= '0;
         range_ff <= '1;
         owed_ff  <= rcd_pkg::OWED_RESET;
      end else begin
         count_ff <= count_in;
         code_ff  <= code_in;
         range_ff <= range_in;
         owed_ff  <= owed_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      begin_ff      <= begin_in;
      diff_ff       <= diff_in;
      prod_ff       <= prod_in;
      sub_ff        <= sub_in;
      symbol_ff     <= symbol_in;
      status_ff     <= status_in;
      bytes_owed_ff <= bytes_owed_in;
   end

   assign out_symbol     = symbol_ff;
   assign out_status     = status_ff;
   assign out_bytes_owed = bytes_owed_ff;

endmodule

### hw/rtl/rcd_ctrl.sv
module rcd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  rcd_pkg::kind_type   in_kind,
   output logic                in_ready,
   output logic                out_valid,
   input  logic                out_ready,
   input  rcd_pkg::status_type status,
   output rcd_pkg::cmd_type    cmd
);

   typedef enum logic [11:0] {
      ST_IDLE      = 12'b0000_0000_0001,
      ST_LOOP      = 12'b0000_0000_0010,
      ST_PROBE_MUL = 12'b0000_0000_0100,
      ST_PROBE_CMP = 12'b0000_0000_1000,
      ST_FETCH_LO  = 12'b0000_0001_0000,
      ST_FETCH_HI  = 12'b0000_0010_0000,
      ST_MUL_BEGIN = 12'b0000_0100_0000,
      ST_MUL_RANGE = 12'b0000_1000_0000,
      ST_CHECK     = 12'b0001_0000_0000,
      ST_NORM      = 12'b0010_0000_0000,
      ST_OUT_OK    = 12'b0100_0000_0000,
      ST_OUT_ERR   = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic out_valid_ff, out_valid_in;
   logic accept;
   logic out_free;

   assign in_ready = (state_ff == ST_IDLE);
   assign accept   = in_valid && in_ready;
   assign out_free = !out_valid_ff || out_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel  = rcd_pkg::RD_MID;
      cmd.mul_sel = rcd_pkg::MUL_PROBE;
      cmd.accept  = accept;

      case (state_ff)
         ST_IDLE: begin
            if (accept && (in_kind == rcd_pkg::KIND_DECODE)) begin
               state_in = ST_LOOP;
            end
         end
         ST_LOOP: begin
            // The read at the midpoint is issued here; it is unused once the search closes.
            if (status.search_done) begin
               state_in = status.out_of_table ? ST_OUT_ERR : ST_FETCH_LO;
            end else begin
               state_in = ST_PROBE_MUL;
            end
         end
         ST_PROBE_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_PROBE_CMP;
         end
         ST_PROBE_CMP: begin
            cmd.probe_cmp = 1'b1;
            state_in      = ST_LOOP;
         end
         ST_FETCH_LO: begin
            cmd.rd_sel = rcd_pkg::RD_LO;
            state_in   = ST_FETCH_HI;
         end
         ST_FETCH_HI: begin
            cmd.rd_sel        = rcd_pkg::RD_LO_NEXT;
            cmd.capture_begin = 1'b1;
            state_in          = ST_MUL_BEGIN;
         end
         ST_MUL_BEGIN: begin
            cmd.mul_sel     = rcd_pkg::MUL_BEGIN;
            cmd.mul_en      = 1'b1;
            cmd.capture_end = 1'b1;
            state_in        = ST_MUL_RANGE;
         end
         ST_MUL_RANGE: begin
            cmd.mul_sel     = rcd_pkg::MUL_RANGE;
            cmd.mul_en      = 1'b1;
            cmd.capture_sub = 1'b1;
            state_in        = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.range_zero) begin
               state_in = ST_OUT_ERR;
            end else begin
               cmd.commit = 1'b1;
               state_in   = ST_NORM;
            end
         end
         ST_NORM: begin
            if (status.range_low) begin
               cmd.norm_shift = 1'b1;
            end else begin
               state_in = ST_OUT_OK;
            end
         end
         ST_OUT_OK: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_OUT_ERR: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_err  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign out_valid = out_valid_ff;

endmodule
